// ===== hdl/trcm_pkg.sv =====
// Shared types, constants, wiring tables and letter arithmetic for the
// three-rotor cipher machine. No dependencies.
`default_nettype none

package trcm_pkg;

    localparam int LETTERS    = 26;
    localparam int NUM_ROTORS = 5;
    localparam int NUM_REFL   = 2;
    localparam int PLUG_W     = 130;
    localparam int CFG_DW     = 60;
    localparam int PIPE_DEPTH = 9;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [FIFO_AW:0] FIFO_FULL = (FIFO_AW + 1)'(FIFO_DEPTH);

    typedef logic [4:0] letter_t;
    typedef logic [2:0] rotor_t;

    localparam letter_t LETTER_MAX = 5'd25;
    localparam rotor_t  ROTOR_MAX  = 3'd4;

    // input item commands
    localparam logic CMD_PRESS  = 1'b0;
    localparam logic CMD_RELOAD = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_REFLECTOR = 3'd0;
    localparam logic [2:0] CFG_ORDER     = 3'd1;
    localparam logic [2:0] CFG_RING      = 3'd2;
    localparam logic [2:0] CFG_START     = 3'd3;
    localparam logic [2:0] CFG_PLUG_A    = 3'd4;
    localparam logic [2:0] CFG_PLUG_B    = 3'd5;
    localparam logic [2:0] CFG_PLUG_C    = 3'd6;

    localparam logic [8:0] ORDER_RESET = 9'd136;

    // pipeline item
    typedef struct packed {
        logic    cmd;
        letter_t x;
        letter_t d_l;
        letter_t d_m;
        letter_t d_r;
        letter_t pos_l;
        letter_t pos_m;
        letter_t pos_r;
    } stage_t;

    // result item, cipher letter in the low bits
    typedef struct packed {
        logic    key_invalid;
        letter_t right_position;
        letter_t middle_position;
        letter_t left_position;
        letter_t cipher_letter;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } fifo_wr_t;

    localparam letter_t ROTOR_FWD [NUM_ROTORS][LETTERS] = '{
        '{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19,
          5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17,
          5'd2, 5'd9},
        '{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7,
          5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21,
          5'd14, 5'd4},
        '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21,
          5'd25, 5'd13, 5'd24, 5'd4, 5'd14, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18,
          5'd16, 5'd8},
        '{5'd4, 5'd18, 5'd14, 5'd21, 5'd15, 5'd25, 5'd9, 5'd0, 5'd24, 5'd16, 5'd20, 5'd8,
          5'd17, 5'd7, 5'd23, 5'd11, 5'd13, 5'd5, 5'd19, 5'd6, 5'd10, 5'd3, 5'd2, 5'd12,
          5'd22, 5'd1},
        '{5'd21, 5'd25, 5'd1, 5'd17, 5'd6, 5'd8, 5'd19, 5'd24, 5'd20, 5'd15, 5'd18, 5'd3,
          5'd13, 5'd7, 5'd11, 5'd23, 5'd0, 5'd22, 5'd12, 5'd9, 5'd16, 5'd14, 5'd5, 5'd4,
          5'd2, 5'd10}
    };

    localparam letter_t ROTOR_INV [NUM_ROTORS][LETTERS] = '{
        '{5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4,
          5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16,
          5'd14, 5'd9},
        '{5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10,
          5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8,
          5'd21, 5'd18},
        '{5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd25, 5'd4, 5'd20, 5'd5,
          5'd21, 5'd13, 5'd16, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10,
          5'd14, 5'd12},
        '{5'd7, 5'd25, 5'd22, 5'd21, 5'd0, 5'd17, 5'd19, 5'd13, 5'd11, 5'd6, 5'd20, 5'd15,
          5'd23, 5'd16, 5'd2, 5'd4, 5'd9, 5'd12, 5'd1, 5'd18, 5'd10, 5'd3, 5'd24, 5'd14,
          5'd8, 5'd5},
        '{5'd16, 5'd2, 5'd24, 5'd11, 5'd23, 5'd22, 5'd4, 5'd13, 5'd5, 5'd19, 5'd25, 5'd14,
          5'd18, 5'd12, 5'd21, 5'd9, 5'd20, 5'd3, 5'd10, 5'd6, 5'd8, 5'd0, 5'd17, 5'd15,
          5'd7, 5'd1}
    };

    localparam letter_t REFL [NUM_REFL][LETTERS] = '{
        '{5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6,
          5'd14, 5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9,
          5'd0, 5'd19},
        '{5'd5, 5'd21, 5'd15, 5'd9, 5'd8, 5'd0, 5'd14, 5'd24, 5'd4, 5'd3, 5'd17, 5'd25,
          5'd23, 5'd22, 5'd6, 5'd2, 5'd19, 5'd10, 5'd20, 5'd16, 5'd18, 5'd1, 5'd13, 5'd12,
          5'd7, 5'd11}
    };

    localparam letter_t NOTCH [NUM_ROTORS] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

    // value below 52 reduced mod 26
    function automatic letter_t mod26_lt52(input logic [5:0] v);
        logic [5:0] t;
        t = (v >= 6'd26) ? v - 6'd26 : v;
        return t[4:0];
    endfunction

    function automatic letter_t mod26_5(input letter_t v);
        return (v >= 5'd26) ? v - 5'd26 : v;
    endfunction

    function automatic letter_t add_mod(input letter_t a, input letter_t b);
        return mod26_lt52({1'b0, a} + {1'b0, b});
    endfunction

    function automatic letter_t sub_mod(input letter_t a, input letter_t b);
        return mod26_lt52({1'b0, a} + 6'd26 - {1'b0, b});
    endfunction

    // slot number above four falls back to rotor V
    function automatic rotor_t rotor_of(input rotor_t raw);
        return (raw > ROTOR_MAX) ? ROTOR_MAX : raw;
    endfunction

    function automatic letter_t plug_map(input logic [PLUG_W-1:0] plugs, input letter_t x);
        letter_t    off;
        logic [5:0] s;
        logic [5:0] t;
        off = plugs[5*x +: 5];
        s   = {1'b0, x} + {1'b0, off};
        if (s >= 6'd52) begin
            t = s - 6'd52;
        end else if (s >= 6'd26) begin
            t = s - 6'd26;
        end else begin
            t = s;
        end
        return t[4:0];
    endfunction

    function automatic letter_t rot_fwd(input rotor_t r, input letter_t d, input letter_t x);
        return sub_mod(ROTOR_FWD[r][add_mod(x, d)], d);
    endfunction

    function automatic letter_t rot_inv(input rotor_t r, input letter_t d, input letter_t x);
        return sub_mod(ROTOR_INV[r][add_mod(x, d)], d);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/three_rotor_cipher_machine.sv =====
// Top level of the three-rotor cipher machine: config registers, position
// store, nine-stage substitution pipeline. Depends on trcm_pkg, trcm_out_fifo.
//
// Stages: one per substitution; stepping shares stage 0 with the plugboard.
// Throughput: one item per cycle while s_tready is high (the credit count
//   can hold it low); set by the read-modify-write of the rotor position
//   store, with forwarding of the word written last cycle.
// Reset (aresetn low, synchronous): config back to defaults (rotors I II III,
//   reflector B, rings, starts and plugs zero), positions read as zero,
//   pipeline and output FIFO empty. No clearing pass.
`default_nettype none

module three_rotor_cipher_machine (
    input  wire         aclk,
    input  wire         aresetn,
    // config write port
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [59:0] cfg_wdata,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [4:0] plain_letter, [7:5] zero
    input  wire  [0:0]  s_tuser,   // [0] cmd
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // [4:0] cipher_letter, [9:5] left_position,
                                   // [14:10] middle_position,
                                   // [19:15] right_position, [20] key_invalid,
                                   // [23:21] zero
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic        refl_sel_reg;
    logic [8:0]  rotor_order_reg;
    logic [14:0] ring_reg;
    logic [14:0] start_reg;
    logic [59:0] plug_a_reg;
    logic [59:0] plug_b_reg;
    logic [9:0]  plug_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refl_sel_reg    <= 1'b0;
            rotor_order_reg <= trcm_pkg::ORDER_RESET;
            ring_reg        <= '0;
            start_reg       <= '0;
            plug_a_reg      <= '0;
            plug_b_reg      <= '0;
            plug_c_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                trcm_pkg::CFG_REFLECTOR: refl_sel_reg    <= cfg_wdata[0];
                trcm_pkg::CFG_ORDER:     rotor_order_reg <= cfg_wdata[8:0];
                trcm_pkg::CFG_RING:      ring_reg        <= cfg_wdata[14:0];
                trcm_pkg::CFG_START:     start_reg       <= cfg_wdata[14:0];
                trcm_pkg::CFG_PLUG_A:    plug_a_reg      <= cfg_wdata[59:0];
                trcm_pkg::CFG_PLUG_B:    plug_b_reg      <= cfg_wdata[59:0];
                trcm_pkg::CFG_PLUG_C:    plug_c_reg      <= cfg_wdata[9:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    logic [trcm_pkg::PLUG_W-1:0] plug_all;
    trcm_pkg::rotor_t            raw_l, raw_m, raw_r;
    trcm_pkg::rotor_t            rot_l, rot_m, rot_r;

    assign plug_all = {plug_c_reg, plug_b_reg, plug_a_reg};
    assign raw_l    = rotor_order_reg[2:0];
    assign raw_m    = rotor_order_reg[5:3];
    assign raw_r    = rotor_order_reg[8:6];
    assign rot_l    = trcm_pkg::rotor_of(raw_l);
    assign rot_m    = trcm_pkg::rotor_of(raw_m);
    assign rot_r    = trcm_pkg::rotor_of(raw_r);

    // ------------------------------------------------------------------
    // key check: the user must keep config static while items are in
    // flight (the block itself does not enforce it), so a registered copy
    // is good by the time an item reaches the output
    logic key_bad_next;
    logic key_bad_reg;

    always_comb begin
        key_bad_next = 1'b0;
        if (raw_l > trcm_pkg::ROTOR_MAX || raw_m > trcm_pkg::ROTOR_MAX ||
            raw_r > trcm_pkg::ROTOR_MAX) begin
            key_bad_next = 1'b1;
        end
        if (raw_l == raw_m || raw_l == raw_r || raw_m == raw_r) begin
            key_bad_next = 1'b1;
        end
        for (int s = 0; s < 3; s++) begin
            if (ring_reg[5*s +: 5] > trcm_pkg::LETTER_MAX ||
                start_reg[5*s +: 5] > trcm_pkg::LETTER_MAX) begin
                key_bad_next = 1'b1;
            end
        end
        // plugboard must pair letters up
        for (int i = 0; i < trcm_pkg::LETTERS; i++) begin
            if (trcm_pkg::plug_map(plug_all, trcm_pkg::plug_map(plug_all, 5'(i))) != 5'(i))
            begin
                key_bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_bad_reg <= key_bad_next;
    end

    // ------------------------------------------------------------------
    // credits: pipeline plus FIFO never hold more than the FIFO depth
    // ------------------------------------------------------------------
    logic                       in_acc;
    logic                       out_acc;
    logic [trcm_pkg::FIFO_AW:0] inflight_reg;

    assign s_tready = (inflight_reg != trcm_pkg::FIFO_FULL);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            unique case ({in_acc, out_acc})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // rotor position store: one word {right, middle, left}, read every
    // cycle into a register. The word written in the cycle an item is
    // accepted is forwarded to that item.
    // ------------------------------------------------------------------
    logic [14:0] pos_mem [1];
    logic [14:0] pos_rd_reg;
    logic        pos_init_reg;      // store written since reset
    logic        pos_rd_ok_reg;
    logic        fwd_vld_reg;
    logic [14:0] fwd_data_reg;
    logic        pos_we;
    logic [14:0] pos_wdata;
    logic [14:0] pos_cur;

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[0] <= pos_wdata;
        end
        pos_rd_reg   <= pos_mem[0];
        fwd_data_reg <= pos_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_init_reg  <= 1'b0;
            pos_rd_ok_reg <= 1'b0;
            fwd_vld_reg   <= 1'b0;
        end else begin
            if (pos_we) begin
                pos_init_reg <= 1'b1;
            end
            pos_rd_ok_reg <= pos_init_reg;
            fwd_vld_reg   <= pos_we;
        end
    end

    always_comb begin
        priority if (fwd_vld_reg) begin
            pos_cur = fwd_data_reg;
        end else if (pos_rd_ok_reg) begin
            pos_cur = pos_rd_reg;
        end else begin
            pos_cur = '0;
        end
    end

    // ------------------------------------------------------------------
    // substitution pipeline
    //   stage 0: rotor step + store write-back, entry plugboard
    //   stages 1-3: right, middle, left rotors forward
    //   stage 4: reflector
    //   stages 5-7: left, middle, right rotors backward
    //   stage 8: exit plugboard, into the output FIFO
    // ------------------------------------------------------------------
    logic [trcm_pkg::PIPE_DEPTH-1:0] pipe_vld_reg;
    trcm_pkg::stage_t                pipe_reg [trcm_pkg::PIPE_DEPTH];
    trcm_pkg::stage_t                pipe_next [trcm_pkg::PIPE_DEPTH];
    trcm_pkg::stage_t                stage_in;

    logic              mid_notch;
    logic              rgt_notch;
    trcm_pkg::letter_t cur_l, cur_m, cur_r;
    trcm_pkg::letter_t new_l, new_m, new_r;
    trcm_pkg::letter_t cipher;

    assign cur_l = pos_cur[4:0];
    assign cur_m = pos_cur[9:5];
    assign cur_r = pos_cur[14:10];

    assign stage_in = '{
        cmd:   s_tuser[0],
        x:     trcm_pkg::mod26_5(s_tdata[4:0]),
        d_l:   '0,
        d_m:   '0,
        d_r:   '0,
        pos_l: '0,
        pos_m: '0,
        pos_r: '0
    };

    // rotor stepping with the middle rotor's double step; reload items load the start positions
    always_comb begin
        mid_notch = (cur_m == trcm_pkg::NOTCH[rot_m]);
        rgt_notch = (cur_r == trcm_pkg::NOTCH[rot_r]);
        if (pipe_reg[0].cmd) begin
            new_l = trcm_pkg::mod26_5(start_reg[4:0]);
            new_m = trcm_pkg::mod26_5(start_reg[9:5]);
            new_r = trcm_pkg::mod26_5(start_reg[14:10]);
        end else begin
            new_l = mid_notch ? trcm_pkg::add_mod(cur_l, 5'd1) : cur_l;
            new_m = (mid_notch || rgt_notch) ? trcm_pkg::add_mod(cur_m, 5'd1) : cur_m;
            new_r = trcm_pkg::add_mod(cur_r, 5'd1);
        end
    end

    assign pos_we    = pipe_vld_reg[0];
    assign pos_wdata = {new_r, new_m, new_l};

    always_comb begin
        pipe_next[0] = stage_in;
        for (int k = 1; k < trcm_pkg::PIPE_DEPTH; k++) begin
            pipe_next[k] = pipe_reg[k-1];
        end

        pipe_next[1].pos_l = new_l;
        pipe_next[1].pos_m = new_m;
        pipe_next[1].pos_r = new_r;
        pipe_next[1].d_l   = trcm_pkg::sub_mod(new_l, trcm_pkg::mod26_5(ring_reg[4:0]));
        pipe_next[1].d_m   = trcm_pkg::sub_mod(new_m, trcm_pkg::mod26_5(ring_reg[9:5]));
        pipe_next[1].d_r   = trcm_pkg::sub_mod(new_r, trcm_pkg::mod26_5(ring_reg[14:10]));
        pipe_next[1].x     = trcm_pkg::plug_map(plug_all, pipe_reg[0].x);

        pipe_next[2].x = trcm_pkg::rot_fwd(rot_r, pipe_reg[1].d_r, pipe_reg[1].x);
        pipe_next[3].x = trcm_pkg::rot_fwd(rot_m, pipe_reg[2].d_m, pipe_reg[2].x);
        pipe_next[4].x = trcm_pkg::rot_fwd(rot_l, pipe_reg[3].d_l, pipe_reg[3].x);
        pipe_next[5].x = trcm_pkg::REFL[refl_sel_reg][pipe_reg[4].x];
        pipe_next[6].x = trcm_pkg::rot_inv(rot_l, pipe_reg[5].d_l, pipe_reg[5].x);
        pipe_next[7].x = trcm_pkg::rot_inv(rot_m, pipe_reg[6].d_m, pipe_reg[6].x);
        pipe_next[8].x = trcm_pkg::rot_inv(rot_r, pipe_reg[7].d_r, pipe_reg[7].x);
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < trcm_pkg::PIPE_DEPTH; k++) begin
            pipe_reg[k] <= pipe_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= '0;
        end else begin
            pipe_vld_reg <= {pipe_vld_reg[trcm_pkg::PIPE_DEPTH-2:0], in_acc};
        end
    end

    // reload items report a zero letter
    assign cipher = pipe_reg[8].cmd ? 5'd0
                                    : trcm_pkg::plug_map(plug_all, pipe_reg[8].x);

    // ------------------------------------------------------------------
    // output FIFO
    // ------------------------------------------------------------------
    trcm_pkg::fifo_wr_t fifo_wr;
    trcm_pkg::result_t  fifo_rd;

    assign fifo_wr.valid                = pipe_vld_reg[8];
    assign fifo_wr.data.key_invalid     = key_bad_reg;
    assign fifo_wr.data.right_position  = pipe_reg[8].pos_r;
    assign fifo_wr.data.middle_position = pipe_reg[8].pos_m;
    assign fifo_wr.data.left_position   = pipe_reg[8].pos_l;
    assign fifo_wr.data.cipher_letter   = cipher;

    trcm_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (fifo_wr),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (fifo_rd)
    );

    assign m_tdata = {3'b000, fifo_rd};

endmodule

`default_nettype wire

// ===== hdl/trcm_out_fifo.sv =====
// Result item FIFO that parts the cipher pipeline from the output stream.
// Depends on trcm_pkg.
`default_nettype none

module trcm_out_fifo (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire trcm_pkg::fifo_wr_t wr,
    output logic                    rd_valid,
    input  wire                     rd_ready,
    output trcm_pkg::result_t       rd_data
);

    trcm_pkg::result_t              mem [trcm_pkg::FIFO_DEPTH];
    logic [trcm_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [trcm_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [trcm_pkg::FIFO_AW:0]     count_reg;
    logic                           pop;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            mem[wr_ptr_reg] <= wr.data;
        end
    end

    // space is guaranteed upstream by credits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({wr.valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/trcm_checker.sv =====
// Port-level checks for the three-rotor cipher machine, bound to its top.
// Depends on three_rotor_cipher_machine's port list.
`default_nettype none

module trcm_port_checks (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // letters and positions stay in range, padding is zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[4:0] < 5'd26) && (m_tdata[9:5] < 5'd26) &&
                     (m_tdata[14:10] < 5'd26) && (m_tdata[19:15] < 5'd26) &&
                     (m_tdata[23:21] == 3'd0))
        else $error("result item field out of range");

    // reset empties the block and reopens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

endmodule

bind three_rotor_cipher_machine trcm_port_checks u_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/trcm_checker.sv =====
// Result checker for the three-rotor cipher machine: follows config writes,
// predicts every result item from its own rotor model and compares.
// Depends on trcm_pkg (result_t, register indexes, commands).
`timescale 1ns / 1ps

module trcm_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [59:0] cfg_wdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,   // [4:0] plain_letter, [7:5] zero
    input  wire  [0:0]  s_tuser,   // [0] cmd
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [23:0] m_tdata,   // [4:0] cipher, [9:5] left, [14:10] middle,
                                   // [19:15] right, [20] key_invalid
    output int          errors,
    output int          pending
);

    localparam int   NLET       = 26;
    localparam int   ASCII_A    = 65;

    // shadow of the key registers and of the rotor positions (left, middle, right)
    logic              refl_sel;
    logic [8:0]        order_reg;
    logic [14:0]       ring_reg;
    logic [14:0]       start_reg;
    logic [59:0]       plug_a;
    logic [59:0]       plug_b;
    logic [9:0]        plug_c;
    int                rotor_pos [3];
    trcm_pkg::result_t expected_q [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    // historical wirings I..V, letter i at character i
    function automatic int wiring(input int r, input int i);
        logic [8*NLET-1:0] w;
        case (r)
            0:       w = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
            1:       w = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
            2:       w = "BDFHJLCPRTXVZNYEOWGAKMUSQI";
            3:       w = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
            default: w = "VZBRGITYUPSDNHLXAWMJQOFECK";
        endcase
        return int'(w[8*(NLET-1-i) +: 8]) - ASCII_A;
    endfunction

    function automatic int reflect(input logic sel, input int i);
        logic [8*NLET-1:0] w;
        w = sel ? "FVPJIAOYEDRZXWGCTKUQSBNMHL" : "YRUHQSLDPXNGOKMIEBFZCWVJAT";
        return int'(w[8*(NLET-1-i) +: 8]) - ASCII_A;
    endfunction

    // turnover letters Q E V J Z
    function automatic int notch(input int r);
        case (r)
            0:       return 16;
            1:       return 4;
            2:       return 21;
            3:       return 9;
            default: return 25;
        endcase
    endfunction

    function automatic int rotor_in_slot(input int s);
        int raw;
        raw = int'(order_reg[3*s +: 3]);
        return (raw > 4) ? 4 : raw;
    endfunction

    function automatic int plug_partner(input int x);
        logic [129:0] plugs;
        plugs = {plug_c, plug_b, plug_a};
        return (x + int'(plugs[5*x +: 5])) % NLET;
    endfunction

    function automatic int through(input int r, input int d, input int x);
        return (wiring(r, (x + d) % NLET) + NLET - d) % NLET;
    endfunction

    function automatic int back(input int r, input int d, input int x);
        int c;
        int i;
        c = (x + d) % NLET;
        for (i = 0; i < NLET; i++)
            if (wiring(r, i) == c) break;
        return (i + NLET - d) % NLET;
    endfunction

    function automatic logic key_broken();
        int i;
        int j;
        for (i = 0; i < 3; i++) begin
            if (order_reg[3*i +: 3] > 3'd4 || ring_reg[5*i +: 5] > 5'd25 ||
                start_reg[5*i +: 5] > 5'd25)
                return 1'b1;
            for (j = 0; j < i; j++)
                if (order_reg[3*i +: 3] == order_reg[3*j +: 3]) return 1'b1;
        end
        for (i = 0; i < NLET; i++)
            if (plug_partner(plug_partner(i)) != i) return 1'b1;
        return 1'b0;
    endfunction

    // advances the shadow positions (a reload sets them to the starts) and returns the result item
    function automatic trcm_pkg::result_t encipher_item(input logic cmd,
                                                        input logic [4:0] plain);
        trcm_pkg::result_t r;
        int                x;
        int                d [3];
        logic              turn_mid;
        logic              turn_right;
        int                k;
        x = 0;
        if (cmd == trcm_pkg::CMD_RELOAD) begin
            for (k = 0; k < 3; k++) rotor_pos[k] = int'(start_reg[5*k +: 5]) % NLET;
        end else begin
            // stepping happens before the letter goes through, double step at middle notch
            turn_mid   = rotor_pos[1] == notch(rotor_in_slot(1));
            turn_right = rotor_pos[2] == notch(rotor_in_slot(2));
            if (turn_mid) rotor_pos[0] = (rotor_pos[0] + 1) % NLET;
            if (turn_mid || turn_right) rotor_pos[1] = (rotor_pos[1] + 1) % NLET;
            rotor_pos[2] = (rotor_pos[2] + 1) % NLET;
            for (k = 0; k < 3; k++)
                d[k] = (rotor_pos[k] + NLET - int'(ring_reg[5*k +: 5]) % NLET) % NLET;
            x = plug_partner(int'(plain) % NLET);
            x = through(rotor_in_slot(2), d[2], x);
            x = through(rotor_in_slot(1), d[1], x);
            x = through(rotor_in_slot(0), d[0], x);
            x = reflect(refl_sel, x);
            x = back(rotor_in_slot(0), d[0], x);
            x = back(rotor_in_slot(1), d[1], x);
            x = back(rotor_in_slot(2), d[2], x);
            x = plug_partner(x);
        end
        r.cipher_letter   = 5'(x);
        r.left_position   = 5'(rotor_pos[0]);
        r.middle_position = 5'(rotor_pos[1]);
        r.right_position  = 5'(rotor_pos[2]);
        r.key_invalid     = key_broken();
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("%0t trcm_checker: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        trcm_pkg::result_t got;
        trcm_pkg::result_t want;
        if (!aresetn) begin
            refl_sel  = 1'b0;
            order_reg = trcm_pkg::ORDER_RESET;
            ring_reg  = '0;
            start_reg = '0;
            plug_a    = '0;
            plug_b    = '0;
            plug_c    = '0;
            rotor_pos = '{0, 0, 0};
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[20:0];
                if (expected_q.size() == 0) begin
                    report("result item with nothing expected, cipher_letter",
                           got.cipher_letter, -1);
                end else begin
                    want = expected_q.pop_front();
                    if (got.cipher_letter != want.cipher_letter)
                        report("cipher_letter", got.cipher_letter, want.cipher_letter);
                    if (got.left_position != want.left_position)
                        report("left_position", got.left_position, want.left_position);
                    if (got.middle_position != want.middle_position)
                        report("middle_position", got.middle_position, want.middle_position);
                    if (got.right_position != want.right_position)
                        report("right_position", got.right_position, want.right_position);
                    if (got.key_invalid != want.key_invalid)
                        report("key_invalid", got.key_invalid, want.key_invalid);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    trcm_pkg::CFG_REFLECTOR: refl_sel  = cfg_wdata[0];
                    trcm_pkg::CFG_ORDER:     order_reg = cfg_wdata[8:0];
                    trcm_pkg::CFG_RING:      ring_reg  = cfg_wdata[14:0];
                    trcm_pkg::CFG_START:     start_reg = cfg_wdata[14:0];
                    trcm_pkg::CFG_PLUG_A:    plug_a    = cfg_wdata;
                    trcm_pkg::CFG_PLUG_B:    plug_b    = cfg_wdata;
                    trcm_pkg::CFG_PLUG_C:    plug_c    = cfg_wdata[9:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(encipher_item(s_tuser[0], s_tdata[4:0]));
        end
        pending = expected_q.size();
    end

endmodule

// ===== bench/tb_three_rotor_cipher_machine.sv =====
// Testbench top for the three-rotor cipher machine: clock, reset, stimulus
// and verdict. Depends on trcm_pkg, three_rotor_cipher_machine, trcm_checker.
`timescale 1ns / 1ps

module tb_three_rotor_cipher_machine;

    localparam int   CYCLE_LIMIT = 300000;
    localparam int   SETTLE      = 16;   // 9-stage pipe plus margin
    localparam int   PHASES      = 14;
    localparam int   PHASE_ITEMS = 100;

    // one complete key: everything the config port can hold
    typedef struct packed {
        logic         refl;
        logic [8:0]   order;
        logic [14:0]  ring;
        logic [14:0]  start;
        logic [129:0] plugs;
    } key_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_wdata;
    logic        s_tvalid;
    wire         s_tready;
    logic [7:0]  s_tdata;    // [4:0] plain_letter, [7:5] zero
    logic [0:0]  s_tuser;    // [0] cmd
    wire         m_tvalid;
    logic        m_tready;
    wire  [23:0] m_tdata;    // [4:0] cipher, [9:5] left, [14:10] middle,
                             // [19:15] right, [20] key_invalid
    int          errors;
    int          pending;
    int          cycles = 0;
    logic        steady;     // both sides run without idling while set

    three_rotor_cipher_machine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    trcm_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog: a hang or a lost result ends here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_three_rotor_cipher_machine: done, errors");
            $finish;
        end
    end

    // result side: random stall ahead of every item, none while steady is set
    initial begin : sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one item on the input channel; valid is only touched once per falling edge
    task automatic send_item(input logic cmd, input logic [4:0] letter);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, letter};
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off input until every result is back and the pipe is quiet
    task automatic drain();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [59:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    // key changes only with the machine idle; every register is written each time
    task automatic load_key(input key_t k);
        drain();
        write_reg(trcm_pkg::CFG_REFLECTOR, 60'(k.refl));
        write_reg(trcm_pkg::CFG_ORDER,     60'(k.order));
        write_reg(trcm_pkg::CFG_RING,      60'(k.ring));
        write_reg(trcm_pkg::CFG_START,     60'(k.start));
        write_reg(trcm_pkg::CFG_PLUG_A,    k.plugs[59:0]);
        write_reg(trcm_pkg::CFG_PLUG_B,    k.plugs[119:60]);
        write_reg(trcm_pkg::CFG_PLUG_C,    60'(k.plugs[129:120]));
    endtask

    // random involution: shuffled letters paired off, the rest self-steckered;
    // an offset of 26..31 that lands on the same partner is mixed in
    function automatic logic [129:0] random_plugboard();
        int           perm [26];
        int           i;
        int           j;
        int           t;
        int           pairs;
        int           a;
        int           b;
        int           off;
        logic [129:0] p;
        for (i = 0; i < 26; i++) perm[i] = i;
        for (i = 25; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < 26; i++) p[5*i +: 5] = ($urandom_range(0, 3) == 0) ? 5'd26 : 5'd0;
        pairs = $urandom_range(0, 13);
        for (i = 0; i < pairs; i++) begin
            a   = perm[2*i];
            b   = perm[2*i+1];
            off = (b - a + 26) % 26;
            if (off <= 5 && $urandom_range(0, 1) == 1) off += 26;
            p[5*a +: 5] = 5'(off);
            off = (a - b + 26) % 26;
            if (off <= 5 && $urandom_range(0, 1) == 1) off += 26;
            p[5*b +: 5] = 5'(off);
        end
        return p;
    endfunction

    function automatic key_t random_valid_key();
        key_t k;
        int   r0;
        int   r1;
        int   r2;
        r0 = $urandom_range(0, 4);
        do r1 = $urandom_range(0, 4); while (r1 == r0);
        do r2 = $urandom_range(0, 4); while (r2 == r0 || r2 == r1);
        k.refl  = 1'($urandom_range(0, 1));
        k.order = {3'(r2), 3'(r1), 3'(r0)};
        k.ring  = {5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
                   5'($urandom_range(0, 25))};
        k.start = {5'($urandom_range(0, 25)), 5'($urandom_range(0, 25)),
                   5'($urandom_range(0, 25))};
        k.plugs = random_plugboard();
        return k;
    endfunction

    // good key with one part spoiled by raw bits, or a whole key of raw bits
    function automatic key_t broken_key();
        key_t k;
        int   x;
        k = random_valid_key();
        case ($urandom_range(0, 4))
            0: k.order = 9'($urandom);
            1: k.ring  = 15'($urandom);
            2: k.start = 15'($urandom);
            3: begin
                x = $urandom_range(0, 25);
                k.plugs[5*x +: 5] = 5'($urandom);
            end
            default: k = $bits(key_t)'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom});
        endcase
        return k;
    endfunction

    initial begin : stimulus
        key_t k;
        int   ph;
        int   n;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = trcm_pkg::CMD_PRESS;
        cfg_wr_en = 1'b0;
        cfg_index = trcm_pkg::CFG_REFLECTOR;
        cfg_wdata = '0;
        steady    = 1'b0;
        aresetn   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // default key (I II III, reflector B, all zero): letter extremes,
        // letters above Z, reload with a junk letter
        send_item(trcm_pkg::CMD_PRESS, 5'd0);
        send_item(trcm_pkg::CMD_PRESS, 5'd25);
        send_item(trcm_pkg::CMD_PRESS, 5'd31);
        send_item(trcm_pkg::CMD_PRESS, 5'd26);
        send_item(trcm_pkg::CMD_RELOAD, 5'd31);

        // start just short of the right notch with the middle one short of its own:
        // right turnover, then the double step of middle and left
        k       = '0;
        k.order = trcm_pkg::ORDER_RESET;
        k.start = {5'd20, 5'd3, 5'd0};
        load_key(k);
        send_item(trcm_pkg::CMD_RELOAD, 5'd0);
        send_item(trcm_pkg::CMD_PRESS, 5'd0);
        send_item(trcm_pkg::CMD_PRESS, 5'd25);
        send_item(trcm_pkg::CMD_PRESS, 5'd12);
        send_item(trcm_pkg::CMD_PRESS, 5'd7);
        send_item(trcm_pkg::CMD_PRESS, 5'd31);

        // reflector C, rotors I IV V, rings at 25, positions wrapping past Z,
        // A/Z steckered, B self-steckered through offset 26
        k.refl        = 1'b1;
        k.order       = {3'd4, 3'd3, 3'd0};
        k.ring        = {5'd25, 5'd25, 5'd25};
        k.start       = {5'd24, 5'd9, 5'd25};
        k.plugs       = '0;
        k.plugs[4:0]  = 5'd25;
        k.plugs[9:5]  = 5'd26;
        k.plugs[129:125] = 5'd1;
        load_key(k);
        send_item(trcm_pkg::CMD_RELOAD, 5'd17);
        send_item(trcm_pkg::CMD_PRESS, 5'd0);
        send_item(trcm_pkg::CMD_PRESS, 5'd25);
        send_item(trcm_pkg::CMD_PRESS, 5'd1);
        send_item(trcm_pkg::CMD_PRESS, 5'd31);
        send_item(trcm_pkg::CMD_PRESS, 5'd19);

        // random phases: all-zero key, all-ones key, then mostly good keys;
        // every fourth phase runs without idling on either side
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                k = '0;
            else if (ph == 1)
                k = '1;
            else if ($urandom_range(0, 3) == 0)
                k = broken_key();
            else
                k = random_valid_key();
            load_key(k);
            steady = (ph % 4 == 3);
            send_item(trcm_pkg::CMD_RELOAD, 5'($urandom));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(trcm_pkg::CMD_RELOAD, 5'($urandom));
                else
                    send_item(trcm_pkg::CMD_PRESS, 5'($urandom_range(0, 31)));
            end
        end
        steady = 1'b0;

        drain();
        if (errors == 0)
            $display("tb_three_rotor_cipher_machine: done, clean");
        else
            $display("tb_three_rotor_cipher_machine: done, errors");
        $finish;
    end

endmodule
